>>> src/lkv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_pkg: shared codes for the LRU key-value cache
// Request actions, result outcome codes and the miss value.
// ----------------------------------------------------------------------------
package lkv_pkg;

  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_PUT = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    OUT_GET_MISS  = 3'd0,
    OUT_GET_HIT   = 3'd1,
    OUT_PUT_UPD   = 3'd2,
    OUT_PUT_INS   = 3'd3,
    OUT_PUT_EVICT = 3'd4
  } outcome_t;

  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam int unsigned WORD_W     = 32;

endpackage

>>> src/lru_key_value_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value cache, LRU replacement
// Usage:
//   Raise start with in_action/in_key/in_value; a word is taken at each
//   clock edge where start is high and busy is low. busy stays low, so a
//   new request may enter every cycle.
//   Get returns the stored value (or -1 on a miss) and refreshes the slot.
//   Put updates a present key, fills the lowest free slot, or replaces the
//   least recent slot and reports the removed key in out_evicted_key.
//   Each request yields one result word: out_valid is high for exactly one
//   cycle with out_outcome, out_read_value and out_evicted_key.
//   Each request passes the request register, then the result register.
//   Throughput: one request per cycle; the key compare and rank update
//   sit between the two registers and the cache state is written at the
//   result edge, so a request sees every earlier one.
//   Reset (rst_n low, synchronous) empties the cache and drops any word in
//   flight. The receiver cannot stall: each result must be taken when shown.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int unsigned ENTRIES = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_action,
  input  logic signed [31:0] in_key,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic [2:0]         out_outcome,
  output logic signed [31:0] out_read_value,
  output logic signed [31:0] out_evicted_key
);

  localparam int unsigned AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned FCW = $clog2(ENTRIES + 1);
  localparam int unsigned W   = lkv_pkg::WORD_W;

  // request register
  logic                in_valid_r;
  lkv_pkg::action_t    action_r;
  logic [W-1:0]        key_r;
  logic [W-1:0]        value_r;

  // cache state
  logic [ENTRIES-1:0]  valid_r;
  logic [W-1:0]        ekey_r  [ENTRIES];
  logic [W-1:0]        edata_r [ENTRIES];
  logic [AW-1:0]       age_r   [ENTRIES];
  logic [AW-1:0]       age_nxt [ENTRIES];
  logic [FCW-1:0]      fill_r;

  // result register
  logic                out_valid_r;
  lkv_pkg::outcome_t   outcome_r;
  logic [W-1:0]        rd_r;
  logic [W-1:0]        ev_r;

  logic [ENTRIES-1:0]  hit_oh;
  logic [ENTRIES-1:0]  free_oh;
  logic [ENTRIES-1:0]  victim_oh;
  logic [ENTRIES-1:0]  touch_oh;
  logic                hit;
  logic                full;
  logic                is_put;
  logic                insert;
  logic [W-1:0]        hit_data;
  logic [W-1:0]        victim_key;
  lkv_pkg::outcome_t   outcome_nxt;
  logic [W-1:0]        rd_nxt;
  logic [W-1:0]        ev_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      action_r <= lkv_pkg::action_t'(in_action);
      key_r    <= in_key;
      value_r  <= in_value;
    end
  end

  lkv_match #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_match (
    .valid     (valid_r),
    .keys      (ekey_r),
    .ages      (age_r),
    .key       (key_r),
    .hit_oh    (hit_oh),
    .free_oh   (free_oh),
    .victim_oh (victim_oh)
  );

  assign hit    = |hit_oh;
  assign full   = (fill_r == FCW'(ENTRIES));
  assign is_put = (action_r == lkv_pkg::ACT_PUT);
  assign insert = is_put && !hit && !full;

  always_comb begin
    priority if (hit) begin
      touch_oh = hit_oh;
    end else if (!is_put) begin
      touch_oh = '0;
    end else if (full) begin
      touch_oh = victim_oh;
    end else begin
      touch_oh = free_oh;
    end
  end

  lkv_rank #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_rank (
    .valid    (valid_r),
    .ages     (age_r),
    .touch_oh (touch_oh),
    .insert   (insert),
    .ages_nxt (age_nxt)
  );

  always_comb begin
    hit_data   = '0;
    victim_key = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_data   = hit_data   | (edata_r[i] & {W{hit_oh[i]}});
      victim_key = victim_key | (ekey_r[i]  & {W{victim_oh[i]}});
    end
  end

  always_comb begin
    rd_nxt = '0;
    ev_nxt = '0;
    priority if (!is_put && hit) begin
      outcome_nxt = lkv_pkg::OUT_GET_HIT;
      rd_nxt      = hit_data;
    end else if (!is_put) begin
      outcome_nxt = lkv_pkg::OUT_GET_MISS;
      rd_nxt      = lkv_pkg::MISS_VALUE;
    end else if (hit) begin
      outcome_nxt = lkv_pkg::OUT_PUT_UPD;
    end else if (full) begin
      outcome_nxt = lkv_pkg::OUT_PUT_EVICT;
      ev_nxt      = victim_key;
    end else begin
      outcome_nxt = lkv_pkg::OUT_PUT_INS;
    end
  end

  // control state: valid bits, ranks, fill count, result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= '0;
      end
    end else begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        for (int i = 0; i < ENTRIES; i++) begin
          age_r[i] <= age_nxt[i];
        end
        if (insert) begin
          valid_r <= valid_r | free_oh;
          fill_r  <= fill_r + FCW'(1);
        end
      end
    end
  end

  // payload: stored pairs and the result word
  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      outcome_r <= outcome_nxt;
      rd_r      <= rd_nxt;
      ev_r      <= ev_nxt;
      if (is_put) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (touch_oh[i]) begin
            ekey_r[i]  <= key_r;
            edata_r[i] <= value_r;
          end
        end
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_outcome     = outcome_r;
  assign out_read_value  = rd_r;
  assign out_evicted_key = ev_r;

endmodule

>>> src/lkv_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_match: parallel key compare and slot selection
// Gives one-hot vectors for the lowest matching slot, the lowest free slot
// and the least recent slot.
// ----------------------------------------------------------------------------
module lkv_match #(
  parameter int unsigned ENTRIES = 4,
  parameter int unsigned AW      = 2
) (
  input  logic [ENTRIES-1:0]          valid,
  input  logic [lkv_pkg::WORD_W-1:0]  keys [ENTRIES],
  input  logic [AW-1:0]               ages [ENTRIES],
  input  logic [lkv_pkg::WORD_W-1:0]  key,
  output logic [ENTRIES-1:0]          hit_oh,
  output logic [ENTRIES-1:0]          free_oh,
  output logic [ENTRIES-1:0]          victim_oh
);

  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] free_vec;
  logic [ENTRIES-1:0] old_vec;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid[i] && (keys[i] == key);
      free_vec[i] = !valid[i];
      // the oldest slot holds the top rank once the store is full
      old_vec[i] = (ages[i] == AW'(ENTRIES - 1));
    end
  end

  // keep only the lowest set bit
  assign hit_oh    = hit_vec  & (~hit_vec  + ENTRIES'(1));
  assign free_oh   = free_vec & (~free_vec + ENTRIES'(1));
  assign victim_oh = old_vec  & (~old_vec  + ENTRIES'(1));

endmodule

>>> src/lkv_rank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_rank: recency rank update
// Makes the touched slot most recent and ages the slots that were younger;
// on insert into a free slot every valid slot ages.
// ----------------------------------------------------------------------------
module lkv_rank #(
  parameter int unsigned ENTRIES = 4,
  parameter int unsigned AW      = 2
) (
  input  logic [ENTRIES-1:0] valid,
  input  logic [AW-1:0]      ages [ENTRIES],
  input  logic [ENTRIES-1:0] touch_oh,
  input  logic               insert,
  output logic [AW-1:0]      ages_nxt [ENTRIES]
);

  logic [AW-1:0] old_age;

  always_comb begin
    old_age = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      old_age = old_age | (ages[i] & {AW{touch_oh[i]}});
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (touch_oh[i]) begin
        ages_nxt[i] = '0;
      end else if (valid[i] && (insert || (ages[i] < old_age))) begin
        ages_nxt[i] = ages[i] + AW'(1);
      end else begin
        ages_nxt[i] = ages[i];
      end
    end
  end

endmodule
